FILE: hw/rtl/sble_pkg.sv
package sble_pkg;

  localparam int BYTE_W = 8;
  localparam int RING_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_PUT   = 2'd1,
    OP_GET   = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE         = 3'd0,
    ST_SENDING      = 3'd1,
    ST_SENT         = 3'd2,
    ST_PARITY_RETRY = 3'd3,
    ST_FRAME_RETRY  = 3'd4
  } send_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic              parity_error;
    logic              frame_error;
    logic              tx_complete;
    logic              rx_not_empty;
    logic [BYTE_W-1:0] rx_data;
    logic [BYTE_W-1:0] tx_byte;
    logic              put_reset;
  } req_t;

  typedef struct packed {
    logic              line_write;
    logic [BYTE_W-1:0] line_byte;
    logic              put_done;
    logic              get_valid;
    logic [BYTE_W-1:0] get_byte;
    logic              rx_dropped;
    logic [2:0]        send_status;
  } rsp_t;

endpackage

FILE: hw/rtl/sble_req_if.sv
interface sble_req_if
  import sble_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sble_rsp_if.sv
interface sble_rsp_if
  import sble_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sble_ring.sv
module sble_ring
  import sble_pkg::*;
#(
  parameter int DEPTH = RING_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/smartcard_byte_link_engine_core.sv
// A result is registered: it appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while rsp.ready is high; a get reads the ring memory in the
// accept cycle and the memory's registered read data is the result's get_byte.
// Reset (synchronous, active high) clears the send state, both ring indices,
// the pending flag and the result valid flag; ring contents are not cleared.
module smartcard_byte_link_engine_core
  import sble_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sble_req_if.sink   req,
  sble_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  send_state_t       send_state, send_state_next;
  logic [IDX_W-1:0]  read_index, read_index_next;
  logic [IDX_W-1:0]  write_index, write_index_next;
  logic              rx_pending, rx_pending_next;

  logic              rsp_valid;
  logic              line_write, line_write_next;
  logic [BYTE_W-1:0] line_byte, line_byte_next;
  logic              put_done, put_done_next;
  logic              get_valid, get_valid_next;
  logic              rx_dropped, rx_dropped_next;

  logic              accept;
  logic              busy;
  logic [IDX_W-1:0]  wr_inc, rd_inc;
  logic              push, pop;
  logic [BYTE_W-1:0] rd_data;
  op_t               op;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign op        = op_t'(req.data.operation);
  assign busy      = send_state != ST_IDLE;
  assign wr_inc    = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
  assign rd_inc    = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;

  always_comb begin
    send_state_next  = send_state;
    read_index_next  = read_index;
    write_index_next = write_index;
    rx_pending_next  = rx_pending;
    line_write_next  = 1'b0;
    line_byte_next   = '0;
    put_done_next    = 1'b0;
    get_valid_next   = 1'b0;
    rx_dropped_next  = 1'b0;
    push             = 1'b0;
    pop              = 1'b0;
    unique case (op)
      OP_EVENT: begin
        if (req.data.parity_error && busy) begin
          send_state_next = ST_PARITY_RETRY;
        end else if (req.data.frame_error && busy) begin
          send_state_next = ST_FRAME_RETRY;
        end else if (req.data.tx_complete && busy) begin
          send_state_next = ST_SENT;
        end else if (req.data.rx_not_empty && !busy) begin
          if (wr_inc == read_index) begin
            rx_dropped_next = 1'b1;
          end else begin
            push             = 1'b1;
            write_index_next = wr_inc;
            rx_pending_next  = 1'b1;
          end
        end
      end
      OP_PUT: begin
        if (req.data.put_reset) begin
          send_state_next = ST_IDLE;
          put_done_next   = 1'b1;
        end else if (send_state == ST_IDLE || send_state == ST_PARITY_RETRY ||
                     send_state == ST_FRAME_RETRY) begin
          send_state_next = ST_SENDING;
          line_write_next = 1'b1;
          line_byte_next  = req.data.tx_byte;
        end else if (send_state == ST_SENT) begin
          send_state_next = ST_IDLE;
          put_done_next   = 1'b1;
        end
      end
      OP_GET: begin
        if (rx_pending && read_index != write_index) begin
          pop             = 1'b1;
          get_valid_next  = 1'b1;
          read_index_next = rd_inc;
          if (rd_inc == write_index) begin
            rx_pending_next = 1'b0;
          end
        end
      end
      OP_FLUSH: begin
        send_state_next  = ST_IDLE;
        rx_pending_next  = 1'b0;
        read_index_next  = '0;
        write_index_next = '0;
      end
      default: begin
      end
    endcase
  end

  sble_ring #(
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (accept && push),
    .wr_addr(write_index),
    .wr_data(req.data.rx_data),
    .rd_en  (accept && pop),
    .rd_addr(read_index),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      send_state  <= ST_IDLE;
      read_index  <= '0;
      write_index <= '0;
      rx_pending  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (accept) begin
        send_state  <= send_state_next;
        read_index  <= read_index_next;
        write_index <= write_index_next;
        rx_pending  <= rx_pending_next;
        rsp_valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_write <= line_write_next;
      line_byte  <= line_byte_next;
      put_done   <= put_done_next;
      get_valid  <= get_valid_next;
      rx_dropped <= rx_dropped_next;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.data.line_write  = line_write;
  assign rsp.data.line_byte   = line_byte;
  assign rsp.data.put_done    = put_done;
  assign rsp.data.get_valid   = get_valid;
  assign rsp.data.get_byte    = get_valid ? rd_data : '0;
  assign rsp.data.rx_dropped  = rx_dropped;
  assign rsp.data.send_status = send_state;

endmodule

FILE: tb/sv/tb.sv
module tb
  import sble_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PTR_W = $clog2(RING_DEPTH_DEF);
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst;

  sble_req_if req_ch ();
  sble_rsp_if rsp_ch ();

  smartcard_byte_link_engine_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // link predictor state
  send_state_t      tx_state;
  logic [7:0]       ring_copy [RING_DEPTH_DEF];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic             rx_avail;

  rsp_t link_replies[$];

  int  errors;
  int  n_sent;
  int  n_checked;
  int  n_line_writes;
  int  n_put_done;
  int  n_ring_reads;
  int  n_drops;
  int  stall_cycles;
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_t advance_link(req_t it);
    rsp_t             r;
    logic [PTR_W-1:0] nxt;
    logic             busy;
    r = '0;
    busy = (tx_state != ST_IDLE);
    case (op_t'(it.operation))
      OP_EVENT: begin
        if (it.parity_error && busy) begin
          tx_state = ST_PARITY_RETRY;
        end else if (it.frame_error && busy) begin
          tx_state = ST_FRAME_RETRY;
        end else if (it.tx_complete && busy) begin
          tx_state = ST_SENT;
        end else if (it.rx_not_empty && !busy) begin
          nxt = wr_ptr + 1'b1;
          if (nxt == rd_ptr) begin
            r.rx_dropped = 1'b1;
          end else begin
            ring_copy[wr_ptr] = it.rx_data;
            wr_ptr = nxt;
            rx_avail = 1'b1;
          end
        end
      end
      OP_PUT: begin
        if (it.put_reset) begin
          tx_state = ST_IDLE;
          r.put_done = 1'b1;
        end else if (tx_state == ST_IDLE || tx_state == ST_PARITY_RETRY ||
                     tx_state == ST_FRAME_RETRY) begin
          tx_state = ST_SENDING;
          r.line_write = 1'b1;
          r.line_byte = it.tx_byte;
        end else if (tx_state == ST_SENT) begin
          tx_state = ST_IDLE;
          r.put_done = 1'b1;
        end
      end
      OP_GET: begin
        if (rx_avail && rd_ptr != wr_ptr) begin
          r.get_valid = 1'b1;
          r.get_byte = ring_copy[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          if (rd_ptr == wr_ptr) rx_avail = 1'b0;
        end
      end
      default: begin
        tx_state = ST_IDLE;
        rx_avail = 1'b0;
        rd_ptr = '0;
        wr_ptr = '0;
      end
    endcase
    r.send_status = tx_state;
    return r;
  endfunction

  function automatic req_t rand_item();
    logic [31:0] bits;
    req_t        r;
    bits = $urandom;
    r = bits[$bits(req_t)-1:0];
    return r;
  endfunction

  function automatic req_t mk(op_t op, bit pe, bit fe, bit tc, bit rxne,
                              logic [7:0] rxd, logic [7:0] txb, bit prst);
    req_t r;
    r.operation    = op;
    r.parity_error = pe;
    r.frame_error  = fe;
    r.tx_complete  = tc;
    r.rx_not_empty = rxne;
    r.rx_data      = rxd;
    r.tx_byte      = txb;
    r.put_reset    = prst;
    return r;
  endfunction

  task automatic send_item(req_t it);
    while (!calm && $urandom_range(99) < 8) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    link_replies.push_back(advance_link(it));
    n_sent++;
  endtask

  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (link_replies.size() != 0);
  endtask

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (link_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
      end else begin
        want = link_replies.pop_front();
        n_checked++;
        check_field("line_write", 8'(want.line_write), 8'(got.line_write));
        check_field("line_byte", want.line_byte, got.line_byte);
        check_field("put_done", 8'(want.put_done), 8'(got.put_done));
        check_field("get_valid", 8'(want.get_valid), 8'(got.get_valid));
        check_field("get_byte", want.get_byte, got.get_byte);
        check_field("rx_dropped", 8'(want.rx_dropped), 8'(got.rx_dropped));
        check_field("send_status", 8'(want.send_status), 8'(got.send_status));
        n_line_writes += want.line_write;
        n_put_done    += want.put_done;
        n_ring_reads  += want.get_valid;
        n_drops       += want.rx_dropped;
      end
    end
    rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_directed();
    send_item(mk(OP_GET,   0, 0, 0, 0, 8'h00, 8'h00, 0));
    send_item(mk(OP_EVENT, 1, 1, 1, 1, 8'hff, 8'h00, 0));
    send_item(mk(OP_EVENT, 0, 0, 0, 0, 8'h00, 8'hff, 1));
    send_item(mk(OP_EVENT, 0, 0, 0, 1, 8'h00, 8'hff, 0));
    send_item(mk(OP_PUT,   1, 1, 1, 1, 8'hff, 8'h00, 0));
    send_item(mk(OP_EVENT, 0, 0, 0, 1, 8'h5a, 8'h00, 0));  // rx ignored while sending
    send_item(mk(OP_PUT,   0, 0, 0, 0, 8'h00, 8'haa, 0));  // put while sending
    send_item(mk(OP_EVENT, 1, 1, 1, 1, 8'h00, 8'h00, 0));  // parity wins
    send_item(mk(OP_PUT,   0, 0, 0, 0, 8'h00, 8'hff, 0));  // resend from parity retry
    send_item(mk(OP_EVENT, 0, 1, 1, 0, 8'h00, 8'h00, 0));  // framing beats complete
    send_item(mk(OP_PUT,   0, 0, 0, 0, 8'h00, 8'h3c, 0));
    send_item(mk(OP_EVENT, 0, 0, 1, 0, 8'h00, 8'h00, 0));
    send_item(mk(OP_EVENT, 0, 0, 1, 1, 8'h77, 8'h00, 0));
    send_item(mk(OP_PUT,   0, 0, 0, 0, 8'h00, 8'h11, 0));  // ack from sent
    send_item(mk(OP_PUT,   0, 0, 0, 0, 8'h00, 8'hff, 0));
    send_item(mk(OP_PUT,   0, 0, 0, 0, 8'h00, 8'h00, 1));  // reset while sending
    send_item(mk(OP_PUT,   0, 0, 0, 0, 8'h00, 8'h00, 1));  // reset from idle
    send_item(mk(OP_GET,   1, 1, 1, 1, 8'hff, 8'hff, 1));
    send_item(mk(OP_GET,   0, 0, 0, 0, 8'h00, 8'h00, 0));
    send_item(mk(OP_GET,   0, 0, 0, 0, 8'h00, 8'h00, 0));
    send_item(mk(OP_EVENT, 0, 0, 0, 1, 8'h81, 8'h00, 0));
    send_item(mk(OP_PUT,   0, 0, 0, 0, 8'h00, 8'h7e, 0));
    send_item(mk(OP_FLUSH, 1, 1, 1, 1, 8'hff, 8'hff, 1));
    send_item(mk(OP_GET,   0, 0, 0, 0, 8'h00, 8'h00, 0));
    send_item(mk(OP_EVENT, 1, 0, 0, 1, 8'hc3, 8'h00, 0));
  endtask

  task automatic test_ring_full();
    req_t it;
    send_item(mk(OP_FLUSH, 0, 0, 0, 0, 8'h00, 8'h00, 0));
    repeat (RING_DEPTH_DEF + 2) begin
      it = rand_item();
      it.operation = OP_EVENT;
      it.rx_not_empty = 1'b1;
      send_item(it);
    end
    wait_drain();
    repeat (RING_DEPTH_DEF) begin
      it = rand_item();
      it.operation = OP_GET;
      send_item(it);
    end
  endtask

  task automatic tx_sequence();
    req_t it;
    it = rand_item();
    it.operation = OP_PUT;
    it.put_reset = ($urandom_range(19) == 0);
    send_item(it);
    repeat ($urandom_range(1, 3)) begin
      it = rand_item();
      it.operation = OP_EVENT;
      it.parity_error = ($urandom_range(3) == 0);
      it.frame_error = ($urandom_range(3) == 0);
      it.tx_complete = ($urandom_range(2) != 0);
      send_item(it);
      if ($urandom_range(1)) begin
        it = rand_item();
        it.operation = OP_PUT;
        it.put_reset = 1'b0;
        send_item(it);
      end
    end
    it = rand_item();
    it.operation = OP_PUT;
    it.put_reset = (tx_state != ST_SENT);
    send_item(it);
  endtask

  task automatic test_random_traffic(int count);
    int   stop_at;
    int   pick;
    req_t it;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        tx_sequence();
      end else if (pick < 68) begin
        repeat ($urandom_range(1, 40)) begin
          it = rand_item();
          it.operation = OP_EVENT;
          it.rx_not_empty = ($urandom_range(9) != 0);
          send_item(it);
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 40)) begin
          it = rand_item();
          it.operation = OP_GET;
          send_item(it);
        end
      end else if (pick < 97) begin
        send_item(rand_item());
      end else begin
        it = rand_item();
        it.operation = OP_FLUSH;
        send_item(it);
      end
    end
  endtask

  task automatic test_back_to_back(int count);
    calm = 1'b1;
    test_random_traffic(count);
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_line_writes = 0;
    n_put_done = 0;
    n_ring_reads = 0;
    n_drops = 0;
    stall_cycles = 0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    tx_state = ST_IDLE;
    rd_ptr = '0;
    wr_ptr = '0;
    rx_avail = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_ring_full();
    test_random_traffic(300);
    test_back_to_back(150);
    test_random_traffic(230);

    wait_drain();
    repeat (5) @(posedge clk);
    $display("Ran %0d transactions (directed, full ring, random), checked %0d results",
             n_sent, n_checked);
    $display("Saw %0d line writes, %0d put acks, %0d ring reads, %0d full-ring drops",
             n_line_writes, n_put_done, n_ring_reads, n_drops);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: smartcard_byte_link_engine_core.f
hw/rtl/sble_pkg.sv
hw/rtl/sble_req_if.sv
hw/rtl/sble_rsp_if.sv
hw/rtl/sble_ring.sv
hw/rtl/smartcard_byte_link_engine_core.sv
tb/sv/tb.sv
